// ===== src/pgrs_pkg.sv =====
package pgrs_pkg;

    // default table depth
    localparam int DEF_MAX_RANGES = 64;

    // operation codes carried in the func field
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_READ   = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the accepted word
        logic pass_start;  // begin a sweep over the used slots
        logic compact;     // sweep mode: 1 compact, 0 merge
        logic rd_slot;     // read the requested slot
        logic append;      // write the merged range after the last kept slot
        logic clear;       // empty the table
        logic drop;        // flag the insert as lost
        logic out_load;    // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pass_done;   // no sweep in flight
        logic changed;     // the last merge sweep grew the range
        logic drop_cond;   // nothing merged and the table is full
        logic out_free;    // result register can take a word
    } t_sts;

    // two ranges join when they overlap, or touch and one is a single page
    function automatic logic f_joins(
        input logic [15:0] alo,
        input logic [15:0] ahi,
        input logic [15:0] blo,
        input logic [15:0] bhi
    );
        logic ov;
        logic sp;
        logic adj;
        ov  = (alo <= bhi) && (blo <= ahi);
        sp  = (alo == ahi) || (blo == bhi);
        adj = (({1'b0, ahi} + 17'd1) == {1'b0, blo}) ||
              (({1'b0, bhi} + 17'd1) == {1'b0, alo});
        return ov || (sp && adj);
    endfunction

endpackage

// ===== src/page_range_set_merge.sv =====
// Page range set: keeps up to MAX_RANGES page ranges, packed into the low slots.
// Slave channel: one word per operation; func selects insert, read slot or clear
// (code three does nothing and only reports the count). Master channel: one
// result word per accepted word, in order.
// Insert orders the two ends, then sweeps the used slots repeatedly, growing
// the range over every slot it joins, until a sweep leaves it unchanged; one
// more sweep compacts the untouched slots and the range is appended. If no
// slot joined and the table is full, the word is flagged dropped instead.
// Every sweep reads one slot per cycle from the table memory. A dropped insert
// skips the compacting sweep and the append.
// One word is worked on at a time; the next word is accepted once the
// current result sits in the output register, even while it waits.
// Reset empties the table and the output register; no clearing pass is needed.
// When the receiver stalls, the result is held and the block waits for it
// to be taken before finishing the next word.
module page_range_set_merge #(
    parameter int MAX_RANGES = pgrs_pkg::DEF_MAX_RANGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], first_page[17:2], last_page[33:18], slot[39:34]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot_low[15:0], slot_high[31:16], slot_used[32], range_total[39:33],
    // dropped[40], zero fill[47:41]
    output logic [47:0] m_axis_tdata
);

    pgrs_pkg::t_cmd w_cmd;
    pgrs_pkg::t_sts w_sts;
    logic [15:0]    w_slot_low;
    logic [15:0]    w_slot_high;
    logic           w_slot_used;
    logic [6:0]     w_range_total;
    logic           w_dropped;

    pgrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_func  (s_axis_tdata[1:0]),
        .i_sts   (w_sts),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd)
    );

    pgrs_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_func        (s_axis_tdata[1:0]),
        .i_first_page  (s_axis_tdata[17:2]),
        .i_last_page   (s_axis_tdata[33:18]),
        .i_slot        (s_axis_tdata[39:34]),
        .i_out_ready   (m_axis_tready),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_slot_low    (w_slot_low),
        .o_slot_high   (w_slot_high),
        .o_slot_used   (w_slot_used),
        .o_range_total (w_range_total),
        .o_dropped     (w_dropped)
    );

    // result word packing
    assign m_axis_tdata = {7'd0, w_dropped, w_range_total, w_slot_used,
                           w_slot_high, w_slot_low};

    // one word in flight: no accept right after an accept
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("word accepted while another is in work");

    // a sweep only starts once the previous one has drained
    a_sweep_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pass_start |-> w_sts.pass_done)
        else $error("sweep started while one is in flight");

    // the result register is never overwritten while it holds a word
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over a pending word");

    // a dropped insert never reports slot contents
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[40] && m_axis_tdata[32]))
        else $error("dropped result carries slot data");

endmodule

// ===== src/pgrs_ctrl.sv =====
module pgrs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_func,
    input  pgrs_pkg::t_sts i_sts,
    output logic           o_ready,
    output pgrs_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MERGE_GO,
        S_MERGE_RUN,
        S_COMPACT_GO,
        S_COMPACT_RUN,
        S_APPEND,
        S_READ,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state r_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_func)
                            pgrs_pkg::FN_INSERT: r_state <= S_MERGE_GO;
                            pgrs_pkg::FN_READ:   r_state <= S_READ;
                            pgrs_pkg::FN_CLEAR:  r_state <= S_CLEAR;
                            default:             r_state <= S_DONE;
                        endcase
                    end
                end
                S_MERGE_GO:   r_state <= S_MERGE_RUN;
                S_MERGE_RUN: begin
                    if (i_sts.pass_done) begin
                        if (i_sts.changed) begin
                            r_state <= S_MERGE_GO;
                        end else if (i_sts.drop_cond) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_COMPACT_GO;
                        end
                    end
                end
                S_COMPACT_GO:  r_state <= S_COMPACT_RUN;
                S_COMPACT_RUN: begin
                    if (i_sts.pass_done) begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: r_state <= S_DONE;
                S_READ:   r_state <= S_DONE;
                S_CLEAR:  r_state <= S_DONE;
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_ready           = (r_state == S_IDLE);
        o_cmd.load        = (r_state == S_IDLE) && i_valid;
        o_cmd.pass_start  = (r_state == S_MERGE_GO) || (r_state == S_COMPACT_GO);
        o_cmd.compact     = (r_state == S_COMPACT_GO);
        o_cmd.rd_slot     = (r_state == S_READ);
        o_cmd.append      = (r_state == S_APPEND);
        o_cmd.clear       = (r_state == S_CLEAR);
        o_cmd.drop        = (r_state == S_MERGE_RUN) && i_sts.pass_done &&
                            !i_sts.changed && i_sts.drop_cond;
        o_cmd.out_load    = (r_state == S_DONE) && i_sts.out_free;
    end

endmodule

// ===== src/pgrs_dp.sv =====
module pgrs_dp #(
    parameter int MAX_RANGES = pgrs_pkg::DEF_MAX_RANGES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pgrs_pkg::t_cmd i_cmd,
    input  logic [1:0]     i_func,
    input  logic [15:0]    i_first_page,
    input  logic [15:0]    i_last_page,
    input  logic [5:0]     i_slot,
    input  logic           i_out_ready,
    output pgrs_pkg::t_sts o_sts,
    output logic           o_out_valid,
    output logic [15:0]    o_slot_low,
    output logic [15:0]    o_slot_high,
    output logic           o_slot_used,
    output logic [6:0]     o_range_total,
    output logic           o_dropped
);

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int SW = (CW > 6) ? CW : 6;

    // range table
    logic [15:0] mem_lo [MAX_RANGES];
    logic [15:0] mem_hi [MAX_RANGES];

    // control registers
    logic [CW-1:0] r_total;
    logic          r_issuing;
    logic          r_rd_vld;
    logic          r_out_valid;

    // payload registers
    logic [1:0]    r_func;
    logic [5:0]    r_slot;
    logic [15:0]   r_lo;
    logic [15:0]   r_hi;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_k;
    logic          r_compact;
    logic          r_changed;
    logic          r_any_join;
    logic          r_drop;
    logic          r_hit;
    logic [15:0]   r_rd_lo;
    logic [15:0]   r_rd_hi;
    logic [15:0]   r_out_lo;
    logic [15:0]   r_out_hi;
    logic          r_out_used;
    logic [6:0]    r_out_total;
    logic          r_out_drop;

    logic [15:0]   n_lo;
    logic [15:0]   n_hi;
    logic          rd_join;
    logic          rd_en;
    logic [AW-1:0] raddr;
    logic          we;
    logic [15:0]   wdata_lo;
    logic [15:0]   wdata_hi;
    logic          slot_hit;
    logic          merge_hit;

    // join test on the slot just read, and the grown range
    always_comb begin
        rd_join   = pgrs_pkg::f_joins(r_lo, r_hi, r_rd_lo, r_rd_hi);
        merge_hit = r_rd_vld && !r_compact && rd_join;
        n_lo      = (r_rd_lo < r_lo) ? r_rd_lo : r_lo;
        n_hi      = (r_rd_hi > r_hi) ? r_rd_hi : r_hi;
    end

    // table port selection
    always_comb begin
        slot_hit = (SW'(r_slot) < SW'(r_total));
        rd_en    = i_cmd.rd_slot || r_issuing;
        raddr    = i_cmd.rd_slot ? AW'(r_slot) : r_idx;
        we       = i_cmd.append || (r_rd_vld && r_compact && !rd_join);
        wdata_lo = i_cmd.append ? r_lo : r_rd_lo;
        wdata_hi = i_cmd.append ? r_hi : r_rd_hi;
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_lo[r_k[AW-1:0]] <= wdata_lo;
            mem_hi[r_k[AW-1:0]] <= wdata_hi;
        end
        if (rd_en) begin
            r_rd_lo <= mem_lo[raddr];
            r_rd_hi <= mem_hi[raddr];
        end
    end

    // sweep sequencing, count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_issuing   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= r_issuing;
            if (i_cmd.pass_start) begin
                r_issuing <= (r_total != '0);
            end else if (r_issuing && (CW'(r_idx) == r_total - CW'(1))) begin
                r_issuing <= 1'b0;
            end
            if (i_cmd.append) begin
                r_total <= r_k + CW'(1);
            end else if (i_cmd.clear) begin
                r_total <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // operand capture, merge and compact bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_slot     <= i_slot;
            r_lo       <= (i_first_page < i_last_page) ? i_first_page : i_last_page;
            r_hi       <= (i_first_page < i_last_page) ? i_last_page : i_first_page;
            r_any_join <= 1'b0;
            r_drop     <= 1'b0;
        end
        if (i_cmd.pass_start) begin
            r_idx     <= '0;
            r_k       <= '0;
            r_compact <= i_cmd.compact;
            r_changed <= 1'b0;
        end else begin
            if (r_issuing) begin
                r_idx <= AW'(r_idx + 1'b1);
            end
            if (merge_hit) begin
                r_lo       <= n_lo;
                r_hi       <= n_hi;
                r_any_join <= 1'b1;
                if ((n_lo != r_lo) || (n_hi != r_hi)) begin
                    r_changed <= 1'b1;
                end
            end
            if (r_rd_vld && r_compact && !rd_join) begin
                r_k <= r_k + CW'(1);
            end
        end
        if (i_cmd.rd_slot) begin
            r_hit <= slot_hit;
        end
        if (i_cmd.drop) begin
            r_drop <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if ((r_func == pgrs_pkg::FN_READ) && r_hit) begin
                r_out_lo   <= r_rd_lo;
                r_out_hi   <= r_rd_hi;
                r_out_used <= 1'b1;
            end else begin
                r_out_lo   <= '0;
                r_out_hi   <= '0;
                r_out_used <= 1'b0;
            end
            r_out_total <= 7'(r_total);
            r_out_drop  <= r_drop;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.pass_done = !r_issuing && !r_rd_vld;
        o_sts.changed   = r_changed;
        o_sts.drop_cond = !r_any_join && (r_total == CW'(MAX_RANGES));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_low    = r_out_lo;
    assign o_slot_high   = r_out_hi;
    assign o_slot_used   = r_out_used;
    assign o_range_total = r_out_total;
    assign o_dropped     = r_out_drop;

endmodule
